### design/rbpl_pkg.sv
// rbpl_pkg: types, sizes and codes for the reference-counted block pool.
// No dependencies; used by refcounted_block_pool_lru.
package rbpl_pkg;

	localparam int BLOCKS   = 256;
	localparam int REF_BITS = 16;
	localparam int IDW      = $clog2(BLOCKS);
	localparam int CNTW     = $clog2(BLOCKS + 1);
	localparam int MW       = REF_BITS + 3;

	localparam logic [2:0] OP_ALLOC = 3'd0;
	localparam logic [2:0] OP_REL   = 3'd1;
	localparam logic [2:0] OP_LOOK  = 3'd2;
	localparam logic [2:0] OP_REG   = 3'd3;
	localparam logic [2:0] OP_RBK   = 3'd4;

	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_MISS  = 3'd1;
	localparam logic [2:0] ST_MERGE = 3'd2;
	localparam logic [2:0] ST_CACHD = 3'd3;
	localparam logic [2:0] ST_EXH   = 3'd4;
	localparam logic [2:0] ST_INV   = 3'd5;
	localparam logic [2:0] ST_SKIP  = 3'd6;

	localparam int FL_FREE   = 0;
	localparam int FL_CACHED = 1;
	localparam int FL_LRU    = 2;

	typedef struct packed {
		logic [2:0]  op;
		logic [7:0]  blk;
		logic [63:0] key_hash;
		logic [8:0]  request_count;
	} cmd_t;

	typedef struct packed {
		logic [7:0] result_block;
		logic [2:0] status;
		logic       evicted;
		logic [8:0] free_count;
		logic [8:0] idle_count;
	} rsp_t;

	typedef struct packed {
		logic [REF_BITS-1:0] refc;
		logic [2:0]          flags;
	} meta_t;

endpackage

### design/refcounted_block_pool_lru.sv
// refcounted_block_pool_lru: top level of the block pool with prefix LRU cache.
// Depends on rbpl_pkg and rbpl_ram.
//
// Usage: pulse start with a command while busy is low; one result beat follows
// with done high for one cycle, and it cannot be stalled. Allocate passes
// through S_ALRD and S_ALWR, release and rollback through S_RDID and S_CHK,
// before the result beat in S_DONE; rejected commands go straight to S_DONE.
// Lookup, and register for an in-use uncached block, scan the per-block hash and
// metadata RAM one entry per cycle until a hit or the end of blocks_in_use;
// that single read port sets the rate. After reset and after every
// blocks_in_use write the block runs a clearing pass over every entry of its
// metadata and ring RAMs with busy high. cfg_ready is always high.
module refcounted_block_pool_lru
	import rbpl_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  cmd_t            cmd,
	output logic            done,
	output rsp_t            rsp,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [CNTW-1:0] cfg_data
);

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_CLR   = 11'b00000000010,
		S_ALRD  = 11'b00000000100,
		S_ALWR  = 11'b00000001000,
		S_RDID  = 11'b00000010000,
		S_CHK   = 11'b00000100000,
		S_SRCH  = 11'b00001000000,
		S_UNL   = 11'b00010000000,
		S_HITWR = 11'b00100000000,
		S_IDWR  = 11'b01000000000,
		S_DONE  = 11'b10000000000
	} state_t;

	state_t state_q, state_d;
	logic [CNTW-1:0] n_q, n_d, fc_q, fc_d, lc_q, lc_d, scan_q, scan_d;
	logic [IDW-1:0]  fh_q, fh_d, lh_q, lh_d, lt_q, lt_d, clr_q, clr_d;
	logic [IDW-1:0]  chk_idx_q, chk_idx_d, c_q, c_d;
	logic            chk_vld_q, chk_vld_d;
	cmd_t            cmd_q, cmd_d;
	logic [7:0]      res_q, res_d;
	logic [2:0]      st_q, st_d;
	logic            ev_q, ev_d;
	meta_t           c_meta_q, c_meta_d, id_meta_q, id_meta_d;

	logic            meta_we, hash_we, ring_we, nxt_we, prv_we;
	logic [IDW-1:0]  meta_wa, meta_ra, ring_wa, ring_ra, nxt_wa, prv_wa, lnk_ra;
	meta_t           meta_wd, md;
	logic [MW-1:0]   meta_rd;
	logic [IDW-1:0]  ring_wd, ring_rd, nxt_wd, prv_wd, next_rd, prev_rd;
	logic [63:0]     hash_rd;
	logic [IDW-1:0]  id;
	logic [REF_BITS-1:0] nref;
	logic            do_lru_push, do_free_push, hit;
	logic [CNTW:0]   avail;
	logic [CNTW-1:0] clamp;

	assign md        = meta_t'(meta_rd);
	assign id        = cmd_q.blk[IDW-1:0];
	assign avail     = {1'b0, fc_q} + {1'b0, lc_q};
	assign cfg_ready = 1'b1;
	assign busy      = (state_q != S_IDLE);
	assign done      = (state_q == S_DONE);
	assign hit       = chk_vld_q && md.flags[FL_CACHED] && (hash_rd == cmd_q.key_hash);

	always_comb begin
		if (cfg_data == '0) begin
			clamp = CNTW'(1);
		end else if (cfg_data > CNTW'(BLOCKS)) begin
			clamp = CNTW'(BLOCKS);
		end else begin
			clamp = cfg_data;
		end
	end

	always_comb begin
		state_d = state_q; n_d = n_q; fc_d = fc_q; lc_d = lc_q; scan_d = scan_q;
		fh_d = fh_q; lh_d = lh_q; lt_d = lt_q; clr_d = clr_q;
		chk_idx_d = chk_idx_q; chk_vld_d = chk_vld_q; c_d = c_q;
		cmd_d = cmd_q; res_d = res_q; st_d = st_q; ev_d = ev_q;
		c_meta_d = c_meta_q; id_meta_d = id_meta_q;
		meta_we = 1'b0; meta_wa = id; meta_wd = '0; meta_ra = id;
		hash_we = 1'b0;
		ring_we = 1'b0; ring_wa = fh_q + fc_q[IDW-1:0]; ring_wd = id; ring_ra = fh_q;
		nxt_we = 1'b0; nxt_wa = lt_q; nxt_wd = id;
		prv_we = 1'b0; prv_wa = id; prv_wd = lt_q;
		lnk_ra = c_q;
		do_lru_push = 1'b0; do_free_push = 1'b0;
		nref = md.refc - REF_BITS'(1);

		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd_d  = cmd;
					res_d  = '0;
					ev_d   = 1'b0;
					st_d   = ST_INV;
					scan_d = '0;
					chk_vld_d = 1'b0;
					case (cmd.op)
						OP_ALLOC: begin
							if (cmd.request_count == '0) begin
								state_d = S_DONE;
							end else if (cmd.request_count > n_q ||
								{1'b0, cmd.request_count} > avail) begin
								st_d = ST_EXH;
								state_d = S_DONE;
							end else begin
								state_d = S_ALRD;
							end
						end
						OP_REL, OP_REG, OP_RBK: begin
							if ({1'b0, cmd.blk} < n_q) begin
								state_d = S_RDID;
							end else begin
								state_d = S_DONE;
							end
						end
						OP_LOOK: state_d = S_SRCH;
						default: state_d = S_DONE;
					endcase
				end
			end
			S_CLR: begin
				meta_we = 1'b1; meta_wa = clr_q; meta_wd = '0;
				meta_wd.flags[FL_FREE] = 1'b1;
				ring_we = 1'b1; ring_wa = clr_q; ring_wd = clr_q;
				clr_d = clr_q + IDW'(1);
				if (clr_q == IDW'(BLOCKS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_ALRD: begin
				lnk_ra = lh_q;
				state_d = S_ALWR;
			end
			S_ALWR: begin
				lnk_ra = lh_q;
				meta_we = 1'b1; meta_wd.refc = REF_BITS'(1); meta_wd.flags = '0;
				if (fc_q == '0) begin
					ev_d = 1'b1;
					res_d = 8'(lh_q);
					meta_wa = lh_q;
					lc_d = lc_q - CNTW'(1);
					if (lc_q != CNTW'(1)) begin
						lh_d = next_rd;
					end
				end else begin
					res_d = 8'(ring_rd);
					meta_wa = ring_rd;
					fc_d = fc_q - CNTW'(1);
				end
				fh_d = fh_q + IDW'(1);
				st_d = ST_OK;
				state_d = S_DONE;
			end
			S_RDID: state_d = S_CHK;
			S_CHK: begin
				state_d = S_DONE;
				case (cmd_q.op)
					OP_REL: begin
						if (!md.flags[FL_FREE] && md.refc != '0) begin
							meta_we = 1'b1; meta_wd.refc = nref; meta_wd.flags = md.flags;
							if (nref == '0) begin
								if (md.flags[FL_CACHED]) begin
									do_lru_push = 1'b1;
									meta_wd.flags[FL_LRU] = 1'b1;
								end else begin
									do_free_push = 1'b1;
								end
							end
							res_d = cmd_q.blk;
							st_d = ST_OK;
						end
					end
					OP_RBK: begin
						res_d = cmd_q.blk;
						if (!md.flags[FL_CACHED] || md.refc == '0) begin
							st_d = ST_SKIP;
						end else begin
							meta_we = 1'b1; meta_wd.refc = nref; meta_wd.flags = md.flags;
							if (nref == '0 && !md.flags[FL_LRU]) begin
								do_lru_push = 1'b1;
								meta_wd.flags[FL_LRU] = 1'b1;
							end
							st_d = ST_OK;
						end
					end
					default: begin
						if (md.flags[FL_FREE] || md.flags[FL_LRU] || md.refc == '0) begin
							st_d = ST_INV;
						end else if (md.flags[FL_CACHED]) begin
							res_d = cmd_q.blk;
							st_d = ST_CACHD;
						end else begin
							id_meta_d = md;
							state_d = S_SRCH;
						end
					end
				endcase
			end
			S_SRCH: begin
				meta_ra = scan_q[IDW-1:0];
				if (hit) begin
					c_d = chk_idx_q;
					c_meta_d = md;
					state_d = S_UNL;
				end else if (!chk_vld_q && scan_q == n_q) begin
					state_d = S_DONE;
					if (cmd_q.op == OP_LOOK) begin
						st_d = ST_MISS;
					end else begin
						meta_we = 1'b1; meta_wd = id_meta_q;
						meta_wd.flags[FL_CACHED] = 1'b1;
						hash_we = 1'b1;
						res_d = cmd_q.blk;
						st_d = ST_OK;
					end
				end else begin
					chk_vld_d = (scan_q < n_q);
					chk_idx_d = scan_q[IDW-1:0];
					if (scan_q < n_q) begin
						scan_d = scan_q + CNTW'(1);
					end
				end
			end
			S_UNL: state_d = S_HITWR;
			S_HITWR: begin
				meta_we = 1'b1; meta_wa = c_q; meta_wd = c_meta_q;
				if (c_meta_q.flags[FL_LRU]) begin
					meta_wd.refc = REF_BITS'(1);
					meta_wd.flags[FL_LRU] = 1'b0;
					lc_d = lc_q - CNTW'(1);
					if (lc_q != CNTW'(1)) begin
						if (c_q == lh_q) begin
							lh_d = next_rd;
						end else if (c_q == lt_q) begin
							lt_d = prev_rd;
						end else begin
							nxt_we = 1'b1; nxt_wa = prev_rd; nxt_wd = next_rd;
							prv_we = 1'b1; prv_wa = next_rd; prv_wd = prev_rd;
						end
					end
				end else if (c_meta_q.refc != '1) begin
					meta_wd.refc = c_meta_q.refc + REF_BITS'(1);
				end
				res_d = 8'(c_q);
				if (cmd_q.op == OP_LOOK) begin
					st_d = ST_OK;
					state_d = S_DONE;
				end else begin
					state_d = S_IDWR;
				end
			end
			S_IDWR: begin
				meta_we = 1'b1;
				meta_wd.refc = id_meta_q.refc - REF_BITS'(1);
				meta_wd.flags = id_meta_q.flags;
				if (id_meta_q.refc == REF_BITS'(1)) begin
					do_free_push = 1'b1;
				end
				st_d = ST_MERGE;
				state_d = S_DONE;
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase

		if (do_lru_push) begin
			if (lc_q != '0) begin
				nxt_we = 1'b1;
				prv_we = 1'b1;
			end else begin
				lh_d = id;
			end
			lt_d = id;
			lc_d = lc_q + CNTW'(1);
		end
		if (do_free_push) begin
			ring_we = 1'b1;
			fc_d = fc_q + CNTW'(1);
			meta_wd = '0;
			meta_wd.flags[FL_FREE] = 1'b1;
		end

		if (cfg_valid) begin
			n_d = clamp; fc_d = clamp; fh_d = '0;
			lh_d = '0; lt_d = '0; lc_d = '0;
			clr_d = '0;
			state_d = S_CLR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			n_q <= CNTW'(BLOCKS); fc_q <= CNTW'(BLOCKS); lc_q <= '0; scan_q <= '0;
			fh_q <= '0; lh_q <= '0; lt_q <= '0; clr_q <= '0;
			chk_idx_q <= '0; chk_vld_q <= 1'b0; c_q <= '0;
			cmd_q <= '0; res_q <= '0; st_q <= '0; ev_q <= 1'b0;
			c_meta_q <= '0; id_meta_q <= '0;
		end else begin
			state_q <= state_d;
			n_q <= n_d; fc_q <= fc_d; lc_q <= lc_d; scan_q <= scan_d;
			fh_q <= fh_d; lh_q <= lh_d; lt_q <= lt_d; clr_q <= clr_d;
			chk_idx_q <= chk_idx_d; chk_vld_q <= chk_vld_d; c_q <= c_d;
			cmd_q <= cmd_d; res_q <= res_d; st_q <= st_d; ev_q <= ev_d;
			c_meta_q <= c_meta_d; id_meta_q <= id_meta_d;
		end
	end

	assign rsp.result_block = res_q;
	assign rsp.status       = st_q;
	assign rsp.evicted      = ev_q;
	assign rsp.free_count   = fc_q;
	assign rsp.idle_count   = lc_q;

	rbpl_ram #(.W(MW), .D(BLOCKS)) u_meta (
		.clk(clk), .we(meta_we), .waddr(meta_wa), .wdata(MW'(meta_wd)),
		.raddr(meta_ra), .rdata(meta_rd)
	);
	rbpl_ram #(.W(64), .D(BLOCKS)) u_hash (
		.clk(clk), .we(hash_we), .waddr(id), .wdata(cmd_q.key_hash),
		.raddr(meta_ra), .rdata(hash_rd)
	);
	rbpl_ram #(.W(IDW), .D(BLOCKS)) u_ring (
		.clk(clk), .we(ring_we), .waddr(ring_wa), .wdata(ring_wd),
		.raddr(ring_ra), .rdata(ring_rd)
	);
	rbpl_ram #(.W(IDW), .D(BLOCKS)) u_next (
		.clk(clk), .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd),
		.raddr(lnk_ra), .rdata(next_rd)
	);
	rbpl_ram #(.W(IDW), .D(BLOCKS)) u_prev (
		.clk(clk), .we(prv_we), .waddr(prv_wa), .wdata(prv_wd),
		.raddr(lnk_ra), .rdata(prev_rd)
	);

	a_acc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !cfg_valid) |=> busy)
		else $error("accepted beat did not raise busy");
	a_pool_sum: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, fc_q} + {1'b0, lc_q}) <= {1'b0, n_q})
		else $error("free plus idle exceeds pool size");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy || start))
		else $error("result beat without a command in flight");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.status <= ST_SKIP))
		else $error("undefined status code");
endmodule

### design/rbpl_ram.sv
// rbpl_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module rbpl_ram #(
	parameter int W = 8,
	parameter int D = 256
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
